FILE: src/rsc_pkg.sv
// Shared types and constants for the Rabbit stream cipher block.
package rsc_pkg;

  typedef enum logic [1:0] {
    ACT_PROCESS = 2'd0,
    ACT_KEY     = 2'd1,
    ACT_IV      = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_IV       = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CTR,
    ST_MIX,
    ST_FINISH,
    ST_OUT
  } eng_state_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
  } cmd_t;

  typedef logic [7:0][31:0] words_t;

  localparam logic [31:0] CtrInc0 = 32'h4D34D34D;
  localparam logic [31:0] CtrInc1 = 32'hD34D34D3;
  localparam logic [31:0] CtrInc2 = 32'h34D34D34;
  localparam logic [31:0] MaskHi  = 32'hFFFF0000;
  localparam logic [31:0] MaskLo  = 32'h0000FFFF;
  localparam logic [1:0]  SetupRounds = 2'd3;

  function automatic logic [31:0] ctr_inc(input logic [2:0] j);
    logic [31:0] r;
    unique case (j)
      3'd0, 3'd3, 3'd6: r = CtrInc0;
      3'd1, 3'd4, 3'd7: r = CtrInc1;
      default:          r = CtrInc2;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotl16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic logic [31:0] rotl8(input logic [31:0] v);
    return {v[23:0], v[31:24]};
  endfunction

endpackage

FILE: src/rabbit_stream_cipher_top.sv
// Top level of the Rabbit stream cipher block.
// Rabbit stream cipher, 128-bit key and 64-bit IV held in key_low, key_high
// and init_vector (write with cfg_we/cfg_index/cfg_data while idle). The
// slave stream carries commands: tuser selects process (0), key setup (1) or
// IV setup (2); code 3 is dropped. tdata holds the 16-byte block as four
// little-endian words. A process transfer returns one master transfer with the
// block XOR the keystream; setup transfers return nothing. A two-entry queue
// sits between the input side and the round engine. Each round is a counter
// step followed by eight 32-bit squarings and the mix. A block goes through
// take, counter step, mix and a result state that holds while the output
// stalls; key and IV setup go through take, four rounds, then a finishing
// step.
module rabbit_stream_cipher_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // data_word0, data_word1, data_word2, data_word3
  input  logic [1:0]   s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // out_word0, out_word1, out_word2, out_word3
);
  import rsc_pkg::*;

  logic [63:0] key_low, key_high, init_vector;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0; key_high <= '0; init_vector <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_KEY_LOW)  key_low <= cfg_data;
      if (cfg_index == REG_KEY_HIGH) key_high <= cfg_data;
      if (cfg_index == REG_IV)       init_vector <= cfg_data;
    end
  end

  assign in_cmd = '{action: action_t'(s_axis_tuser),
                    word0: s_axis_tdata[31:0], word1: s_axis_tdata[63:32],
                    word2: s_axis_tdata[95:64], word3: s_axis_tdata[127:96]};

  rsc_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd,
    .q_valid, .q_take, .q_cmd
  );

  rsc_engine u_engine (
    .clk, .rst, .key_low, .key_high, .init_vector, .q_valid, .q_take, .q_cmd,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !q_take)
    else $error("engine took a command while holding a result");
endmodule

FILE: src/rsc_front.sv
// Input front end: takes stream items, drops unused codes, two-entry queue.
module rsc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsc_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_take,
  output rsc_pkg::cmd_t q_cmd
);
  import rsc_pkg::*;

  cmd_t       slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && (in_cmd.action != ACT_NONE);
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_cmd    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: src/rsc_engine.sv
// Cipher back end: state registers, counter and g-function round sequencer.
module rsc_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic [63:0]   key_low,
  input  logic [63:0]   key_high,
  input  logic [63:0]   init_vector,
  input  logic          q_valid,
  output logic          q_take,
  input  rsc_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [127:0]  out_data
);
  import rsc_pkg::*;

  eng_state_t state, state_next;
  words_t     x, c, mx, mc;
  logic       carry, mcarry;
  action_t    act;
  logic [1:0] rounds;
  logic [127:0] blk;
  words_t     g;
  words_t     c_step;
  logic       carry_step;
  logic [31:0] k0, k1, k2, k3, i0, i2;
  logic [3:0][31:0] iw;

  assign k0 = key_low[31:0];
  assign k1 = key_low[63:32];
  assign k2 = key_high[31:0];
  assign k3 = key_high[63:32];
  assign i0 = init_vector[31:0];
  assign i2 = init_vector[63:32];
  assign iw[0] = i0;
  assign iw[1] = {i2[31:16], i0[31:16]};
  assign iw[2] = i2;
  assign iw[3] = {i2[15:0], i0[15:0]};

  // counter chain
  always_comb begin
    logic [32:0] s;
    logic        cy;
    cy = carry;
    for (int j = 0; j < 8; j++) begin
      s = {1'b0, c[j]} + {1'b0, ctr_inc(3'(j))} + {32'd0, cy};
      c_step[j] = s[31:0];
      cy = s[32];
    end
    carry_step = cy;
  end

  // eight squarings, feeding the mix in the same cycle
  always_comb begin
    logic [31:0] u;
    logic [63:0] sq;
    for (int j = 0; j < 8; j++) begin
      u = x[j] + c[j];
      sq = {32'd0, u} * {32'd0, u};
      g[j] = sq[31:0] ^ sq[63:32];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (q_valid) state_next = ST_CTR;
      ST_CTR:    state_next = ST_MIX;
      ST_MIX:    if (act == ACT_PROCESS) state_next = ST_OUT;
                 else if (rounds == 2'd0) state_next = ST_FINISH;
                 else state_next = ST_CTR;
      ST_FINISH: state_next = ST_IDLE;
      ST_OUT:    if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_take    = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
  end

  assign out_data = {blk[127:96] ^ x[6] ^ {16'd0, x[3][31:16]} ^ {x[1][15:0], 16'd0},
                     blk[95:64]  ^ x[4] ^ {16'd0, x[1][31:16]} ^ {x[7][15:0], 16'd0},
                     blk[63:32]  ^ x[2] ^ {16'd0, x[7][31:16]} ^ {x[5][15:0], 16'd0},
                     blk[31:0]   ^ x[0] ^ {16'd0, x[5][31:16]} ^ {x[3][15:0], 16'd0}};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      x <= '0; c <= '0; carry <= 1'b0;
      mx <= '0; mc <= '0; mcarry <= 1'b0;
      act <= ACT_PROCESS;
      rounds <= 2'd0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (q_valid) begin
          act <= q_cmd.action;
          blk <= {q_cmd.word3, q_cmd.word2, q_cmd.word1, q_cmd.word0};
          rounds <= SetupRounds;
          if (q_cmd.action == ACT_KEY) begin
            x <= {k2 << 16 | k1 >> 16, k3, k1 << 16 | k0 >> 16, k2,
                  k0 << 16 | k3 >> 16, k1, k3 << 16 | k2 >> 16, k0};
            c <= {(k3 & MaskHi) | (k0 & MaskLo), rotl16(k1),
                  (k2 & MaskHi) | (k3 & MaskLo), rotl16(k0),
                  (k1 & MaskHi) | (k2 & MaskLo), rotl16(k3),
                  (k0 & MaskHi) | (k1 & MaskLo), rotl16(k2)};
            carry <= 1'b0;
          end else if (q_cmd.action == ACT_IV) begin
            x <= mx;
            carry <= mcarry;
            for (int j = 0; j < 8; j++) c[j] <= mc[j] ^ iw[j % 4];
          end
        end
        ST_CTR: begin
          c <= c_step;
          carry <= carry_step;
        end
        ST_MIX: begin
          x[0] <= g[0] + rotl16(g[7]) + rotl16(g[6]);
          x[1] <= g[1] + rotl8(g[0]) + g[7];
          x[2] <= g[2] + rotl16(g[1]) + rotl16(g[0]);
          x[3] <= g[3] + rotl8(g[2]) + g[1];
          x[4] <= g[4] + rotl16(g[3]) + rotl16(g[2]);
          x[5] <= g[5] + rotl8(g[4]) + g[3];
          x[6] <= g[6] + rotl16(g[5]) + rotl16(g[4]);
          x[7] <= g[7] + rotl8(g[6]) + g[5];
          rounds <= rounds - 2'd1;
        end
        ST_FINISH: begin
          if (act == ACT_KEY) begin
            for (int j = 0; j < 8; j++) c[j] <= c[j] ^ x[(j + 4) % 8];
            for (int j = 0; j < 8; j++) mc[j] <= c[j] ^ x[(j + 4) % 8];
            mx <= x;
            mcarry <= carry;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
